// ===== src/pcbp_pkg.sv =====
`default_nettype none

package pcbp_pkg;

  localparam int MAX_CODE_LEN_DEF = 32;
  localparam int SYMBOL_COUNT_DEF = 256;

  localparam int SYM_W  = 8;
  localparam int CODE_W = 32;
  localparam int LEN_W  = 6;
  localparam int BYTE_W = 8;
  localparam int CNT_W  = 16;
  localparam int PEND_W = 7;
  localparam int PCNT_W = 3;
  localparam int ACC_W  = CODE_W + PEND_W;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2
  } op_e;

  typedef struct packed {
    logic [1:0]        operation;
    logic [SYM_W-1:0]  symbol;
    logic [CODE_W-1:0] code_word;
    logic [LEN_W-1:0]  code_length;
  } pcbp_in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last;
    logic              no_code;
    logic [CNT_W-1:0]  byte_count;
  } pcbp_out_t;

endpackage

`default_nettype wire

// ===== src/pcbp_stream_if.sv =====
`default_nettype none

interface pcbp_stream_if #(
  parameter type data_t = logic
) ();
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/prefix_code_bit_packer.sv =====
// Prefix-code encoder with an MSB-first byte packer.
// in_i carries pcbp_in_t items: loads write one codebook entry, encodes
// append the symbol's code bits (or give a no-code result), flushes close
// the block with a padded final byte (or a bare end marker) flagged last.
// out_o carries pcbp_out_t results, one byte per transfer, each with the
// saturating byte count of the block.
// A result passes through the codebook read, the bit merge and the output
// register in that order after its item's transfer.
// Throughput: one item per cycle while each item causes at most one
// result and the receiver does not stall. An encode that completes more
// than one byte holds the byte emitter until it has sent each byte, since
// the output port carries a single byte per transfer. Loads cause no
// result.
// Reset clears the codebook valid marks at once; no clearing pass runs and
// the first item may be sent as soon as reset is released. Bit buffer
// and byte count return to zero.
// When the receiver stalls, the output register holds its result, the
// emitter and merge stage wait behind it, and in_i.ready drops once the
// merge stage is occupied.
`default_nettype none

module prefix_code_bit_packer #(
  parameter int MAX_CODE_LEN = pcbp_pkg::MAX_CODE_LEN_DEF,
  parameter int SYMBOL_COUNT = pcbp_pkg::SYMBOL_COUNT_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  pcbp_stream_if.sink   in_i,
  pcbp_stream_if.source out_o
);
  import pcbp_pkg::*;

  localparam int AW        = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int LEN_BOUND = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LEN_BOUND);
  localparam int ENT_W     = LEN_W + CODE_W;

  localparam logic [1:0] K_DATA   = 2'd0;
  localparam logic [1:0] K_NOCODE = 2'd1;
  localparam logic [1:0] K_FLUSH  = 2'd2;

  typedef struct packed {
    logic [1:0]        kind;
    logic [CODE_W-1:0] word;
    logic [1:0]        idx;
    logic              bump;
  } emit_t;

  // ---------------- input side and codebook ----------------
  pcbp_in_t          in_d;
  logic              in_ready;
  logic              in_fire;
  logic              sym_oor;
  logic [AW-1:0]     addr;
  logic [LEN_W-1:0]  len_sat;
  logic [CODE_W:0]   len_mask;
  logic [CODE_W-1:0] code_masked;

  logic [ENT_W-1:0]  mem_q [SYMBOL_COUNT];
  logic              vld_q [SYMBOL_COUNT];

  assign in_d        = in_i.data;
  assign in_fire     = in_i.valid && in_ready;
  assign sym_oor     = {1'b0, in_d.symbol} >= (SYM_W + 1)'(SYMBOL_COUNT);
  assign addr        = in_d.symbol[AW-1:0];
  assign len_sat     = (in_d.code_length > LEN_MAX) ? LEN_MAX : in_d.code_length;
  assign len_mask    = ((CODE_W + 1)'(1) << len_sat) - (CODE_W + 1)'(1);
  assign code_masked = in_d.code_word & len_mask[CODE_W-1:0];

  logic                     s1_v_q;
  logic                     s1_flush_q;
  logic                     s1_hit_q;
  logic [ENT_W-1:0]         s1_rd_q;
  logic                     s1_adv;
  logic                     e_free;

  always_ff @(posedge clk_i) begin
    if (in_fire && in_d.operation == OP_LOAD && !sym_oor &&
        in_d.code_length != '0) begin
      mem_q[addr] <= {len_sat, code_masked};
    end
    if (in_fire && in_d.operation == OP_ENCODE) begin
      s1_rd_q <= mem_q[addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SYMBOL_COUNT; i++) vld_q[i] <= 1'b0;
    end else if (in_fire && in_d.operation == OP_LOAD && !sym_oor) begin
      vld_q[addr] <= (in_d.code_length != '0);
    end
  end

  // ---------------- merge stage ----------------
  assign s1_adv   = s1_v_q && e_free;
  assign in_ready = !s1_v_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q     <= 1'b0;
      s1_flush_q <= 1'b0;
      s1_hit_q   <= 1'b0;
    end else if (in_ready) begin
      s1_v_q     <= in_fire && (in_d.operation == OP_ENCODE ||
                                in_d.operation == OP_FLUSH);
      s1_flush_q <= in_d.operation == OP_FLUSH;
      s1_hit_q   <= !sym_oor && vld_q[addr];
    end
  end

  logic [PEND_W-1:0] pend_bits_q;
  logic [PCNT_W-1:0] pend_cnt_q;
  logic [LEN_W-1:0]  clen;
  logic [ACC_W-1:0]  acc;
  logic [LEN_W-1:0]  total;
  logic [CODE_W-1:0] full_word;
  logic [2:0]        nbytes;
  logic [PEND_W-1:0] new_pend;
  logic [BYTE_W-1:0] flush_byte;

  assign clen       = s1_rd_q[ENT_W-1:CODE_W];
  assign acc        = ({{CODE_W{1'b0}}, pend_bits_q} << clen) |
                      {{PEND_W{1'b0}}, s1_rd_q[CODE_W-1:0]};
  assign total      = {{(LEN_W - PCNT_W){1'b0}}, pend_cnt_q} + clen;
  assign full_word  = CODE_W'(acc >> total[2:0]);
  assign nbytes     = total[5:3];
  assign new_pend   = acc[PEND_W-1:0] & ~({PEND_W{1'b1}} << total[2:0]);
  assign flush_byte = BYTE_W'({1'b0, pend_bits_q} << (4'd8 - {1'b0, pend_cnt_q}));

  // ---------------- byte emitter and output register ----------------
  logic              e_v_q;
  emit_t             e_q;
  logic              e_fire;
  logic              e_done;
  logic              out_v_q;
  pcbp_out_t         out_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [CNT_W-1:0]  cnt_inc;

  assign e_fire  = e_v_q && (!out_v_q || out_o.ready);
  assign e_done  = e_fire && (e_q.kind != K_DATA || e_q.idx == 2'd0);
  assign e_free  = !e_v_q || e_done;
  assign cnt_inc = (cnt_q == {CNT_W{1'b1}}) ? cnt_q : cnt_q + CNT_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_bits_q <= '0;
      pend_cnt_q  <= '0;
    end else if (s1_adv) begin
      if (s1_flush_q) begin
        pend_bits_q <= '0;
        pend_cnt_q  <= '0;
      end else if (s1_hit_q) begin
        pend_bits_q <= new_pend;
        pend_cnt_q  <= total[2:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_v_q <= 1'b0;
    end else if (s1_adv) begin
      // A code that completes no byte only updates the bit buffer.
      e_v_q <= s1_flush_q || !s1_hit_q || (nbytes != 3'd0);
    end else if (e_done) begin
      e_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      if (s1_flush_q) begin
        e_q.kind <= K_FLUSH;
        e_q.word <= {{(CODE_W - BYTE_W){1'b0}}, flush_byte};
      end else if (!s1_hit_q) begin
        e_q.kind <= K_NOCODE;
        e_q.word <= '0;
      end else begin
        e_q.kind <= K_DATA;
        e_q.word <= full_word;
      end
      e_q.idx  <= 2'(nbytes - 3'd1);
      e_q.bump <= pend_cnt_q != '0;
    end else if (e_fire) begin
      e_q.idx <= e_q.idx - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      if (e_fire) begin
        out_v_q <= 1'b1;
      end else if (out_o.ready) begin
        out_v_q <= 1'b0;
      end
      if (e_fire) begin
        case (e_q.kind)
          K_DATA:  cnt_q <= cnt_inc;
          K_FLUSH: cnt_q <= '0;
          default: cnt_q <= cnt_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (e_fire) begin
      case (e_q.kind)
        K_DATA: begin
          out_q.out_byte   <= e_q.word[{e_q.idx, 3'b000} +: BYTE_W];
          out_q.last       <= 1'b0;
          out_q.no_code    <= 1'b0;
          out_q.byte_count <= cnt_inc;
        end
        K_FLUSH: begin
          out_q.out_byte   <= e_q.word[BYTE_W-1:0];
          out_q.last       <= 1'b1;
          out_q.no_code    <= 1'b0;
          out_q.byte_count <= e_q.bump ? cnt_inc : cnt_q;
        end
        default: begin
          out_q.out_byte   <= '0;
          out_q.last       <= 1'b0;
          out_q.no_code    <= 1'b1;
          out_q.byte_count <= cnt_q;
        end
      endcase
    end
  end

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_v_q;
  assign out_o.data  = out_q;

  // ---------------- assertions ----------------
  a_flush_clears_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (e_fire && e_q.kind == K_FLUSH) |=> (cnt_q == '0))
    else $error("byte count not cleared after block end");

  a_data_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_q.last && !out_q.no_code) |-> (out_q.byte_count != '0))
    else $error("data byte carries a zero byte count");

  a_merge_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && e_v_q && !e_done) |-> !in_ready)
    else $error("input taken while merge stage is held");

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pcbp_pkg::*;

  localparam int          CYCLE_LIMIT = 400000;
  localparam int          LEN_LIMIT   = (MAX_CODE_LEN_DEF < 32) ? MAX_CODE_LEN_DEF : 32;
  localparam logic [1:0]  OP_UNUSED   = 2'd3;
  localparam logic [15:0] COUNT_MAX   = 16'hFFFF;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  pcbp_stream_if #(.data_t(pcbp_in_t))  in_if ();
  pcbp_stream_if #(.data_t(pcbp_out_t)) out_if ();

  prefix_code_bit_packer i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #5 clk_i = ~clk_i;

  // Predicted codebook and bit buffer.
  logic [CODE_W-1:0] cb_word  [256];
  int                cb_len   [256];
  bit                cb_valid [256];
  logic [PEND_W-1:0] acc_bits;
  int                acc_count;
  logic [CNT_W-1:0]  block_bytes;

  pcbp_out_t expected_bytes[$];
  pcbp_out_t head;

  int fail_count;
  int cycle_count;
  int send_idle_pct;
  int recv_idle_pct;
  int stall_left;

  initial begin
    in_if.valid   = 1'b0;
    in_if.data    = '0;
    out_if.ready  = 1'b0;
    fail_count    = 0;
    cycle_count   = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_left    = 0;
    acc_bits      = '0;
    acc_count     = 0;
    block_bytes   = '0;
    foreach (cb_valid[i]) begin
      cb_valid[i] = 1'b0;
      cb_word[i]  = '0;
      cb_len[i]   = 0;
    end
  end

  function automatic pcbp_in_t make_item(logic [1:0] op, int sym, logic [31:0] word, int len);
    pcbp_in_t item;
    item.operation   = op;
    item.symbol      = sym[SYM_W-1:0];
    item.code_word   = word;
    item.code_length = len[LEN_W-1:0];
    return item;
  endfunction

  task automatic push_byte(logic [7:0] value, logic is_last, logic is_nocode);
    pcbp_out_t res;
    res.out_byte   = value;
    res.last       = is_last;
    res.no_code    = is_nocode;
    res.byte_count = block_bytes;
    expected_bytes.push_back(res);
  endtask

  task automatic bump_block_bytes();
    if (block_bytes != COUNT_MAX) begin
      block_bytes = block_bytes + 1'b1;
    end
  endtask

  // Works out the results that one accepted item produces, and tracks the predicted codebook and bit buffer.
  task automatic predict_packing(pcbp_in_t item);
    logic [63:0] acc;
    int          clen;
    int          total;
    int          n;
    int          sym;
    sym = item.symbol;
    case (item.operation)
      OP_LOAD: begin
        if (sym < SYMBOL_COUNT_DEF) begin
          if (item.code_length == 0) begin
            cb_valid[sym] = 1'b0;
          end else begin
            clen = (item.code_length > LEN_LIMIT) ? LEN_LIMIT : int'(item.code_length);
            acc = 64'(item.code_word) & ((64'd1 << clen) - 64'd1);
            cb_word[sym]  = acc[CODE_W-1:0];
            cb_len[sym]   = clen;
            cb_valid[sym] = 1'b1;
          end
        end
      end
      OP_ENCODE: begin
        if (sym >= SYMBOL_COUNT_DEF || !cb_valid[sym]) begin
          push_byte(8'h00, 1'b0, 1'b1);
        end else begin
          clen  = cb_len[sym];
          acc   = (64'(acc_bits) << clen) | 64'(cb_word[sym]);
          total = acc_count + clen;
          n     = 0;
          while (total >= 8 && n < 4) begin
            total = total - 8;
            bump_block_bytes();
            push_byte(8'(acc >> total), 1'b0, 1'b0);
            n++;
          end
          acc       = acc & ((64'd1 << total) - 64'd1);
          acc_bits  = acc[PEND_W-1:0];
          acc_count = total;
        end
      end
      OP_FLUSH: begin
        if (acc_count != 0) begin
          bump_block_bytes();
          push_byte(8'({1'b0, acc_bits} << (8 - acc_count)), 1'b1, 1'b0);
        end else begin
          push_byte(8'h00, 1'b1, 1'b0);
        end
        acc_bits    = '0;
        acc_count   = 0;
        block_bytes = '0;
      end
      default: ;
    endcase
  endtask

  // Offers one item, with a random gap in front, and predicts it once it transfers.
  task automatic send_item(pcbp_in_t item);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      do begin
        @(posedge clk_i);
      end while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= item;
    do begin
      @(posedge clk_i);
    end while (!in_if.ready);
    predict_packing(item);
  endtask

  task automatic stop_sending();
    in_if.valid <= 1'b0;
    in_if.data  <= make_item(OP_UNUSED, $urandom_range(0, 255), $urandom, 0);
  endtask

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected result: out_byte %02h last %0b no_code %0b byte_count %0d",
               out_if.data.out_byte, out_if.data.last, out_if.data.no_code,
               out_if.data.byte_count);
        fail_count++;
      end else begin
        head = expected_bytes.pop_front();
        if (out_if.data.out_byte !== head.out_byte) begin
          $error("out_byte: expected %02h, actual %02h", head.out_byte, out_if.data.out_byte);
          fail_count++;
        end
        if (out_if.data.last !== head.last) begin
          $error("last: expected %0b, actual %0b", head.last, out_if.data.last);
          fail_count++;
        end
        if (out_if.data.no_code !== head.no_code) begin
          $error("no_code: expected %0b, actual %0b", head.no_code, out_if.data.no_code);
          fail_count++;
        end
        if (out_if.data.byte_count !== head.byte_count) begin
          $error("byte_count: expected %0d, actual %0d", head.byte_count,
                 out_if.data.byte_count);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[prefix_code_bit_packer] ERROR");
      $finish;
    end
  end

  // Mostly encodes of symbols that have a code, so the bit buffer keeps wrapping.
  function automatic pcbp_in_t random_item();
    int pick;
    int sym;
    int len;
    pick = $urandom_range(0, 99);
    sym  = $urandom_range(0, 255);
    if (pick < 6) begin
      if (pick == 0) begin
        len = $urandom_range(33, 63);
      end else if (pick == 1) begin
        len = 0;
      end else begin
        len = $urandom_range(1, 32);
      end
      return make_item(OP_LOAD, sym, $urandom, len);
    end else if (pick < 84) begin
      repeat (32) begin
        if (!cb_valid[sym]) begin
          sym = $urandom_range(0, 255);
        end
      end
      return make_item(OP_ENCODE, sym, $urandom, $urandom_range(0, 63));
    end else if (pick < 88) begin
      return make_item(OP_ENCODE, sym, $urandom, $urandom_range(0, 63));
    end else if (pick < 97) begin
      return make_item(OP_FLUSH, sym, $urandom, $urandom_range(0, 63));
    end
    return make_item(OP_UNUSED, sym, $urandom, $urandom_range(0, 63));
  endfunction

  task automatic test_directed();
    send_idle_pct = 19;
    recv_idle_pct = 79;
    send_item(make_item(OP_LOAD, 0, 32'h0000_0001, 1));
    send_item(make_item(OP_LOAD, 255, 32'hFFFF_FFFF, 32));
    // Lengths above the bound are clipped to 32 bits.
    send_item(make_item(OP_LOAD, 8'h55, 32'hA5A5_5A5A, 40));
    // Only the low bits of the word are kept for a short code.
    send_item(make_item(OP_LOAD, 8'hAA, 32'hFFFF_FFF5, 3));
    send_item(make_item(OP_LOAD, 7, 32'h0000_0000, 63));
    send_item(make_item(OP_LOAD, 9, 32'h0000_0013, 5));
    send_item(make_item(OP_LOAD, 9, 32'h0000_0013, 0));
    send_item(make_item(OP_ENCODE, 8'hAA, 32'h0, 0));
    send_item(make_item(OP_ENCODE, 8'hAA, 32'h0, 0));
    send_item(make_item(OP_ENCODE, 0, 32'h0, 0));
    // Seven pending bits plus a full-length code complete four bytes.
    send_item(make_item(OP_ENCODE, 255, 32'h0, 0));
    send_item(make_item(OP_ENCODE, 8'h55, 32'h0, 0));
    send_item(make_item(OP_ENCODE, 7, 32'h0, 0));
    send_item(make_item(OP_ENCODE, 9, 32'h0, 0));
    send_item(make_item(OP_ENCODE, 200, 32'h0, 0));
    send_item(make_item(OP_FLUSH, 0, 32'h0, 0));
    send_item(make_item(OP_FLUSH, 0, 32'h0, 0));
    send_item(make_item(OP_UNUSED, 255, 32'hFFFF_FFFF, 63));
    send_item(make_item(OP_ENCODE, 0, 32'h0, 0));
    send_item(make_item(OP_FLUSH, 0, 32'h0, 0));
  endtask

  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_left    = 400;
    for (int i = 0; i < 40; i++) begin
      send_item(make_item(OP_ENCODE, (i % 3 == 0) ? 8'h55 : 8'd255, $urandom, 0));
    end
    send_item(make_item(OP_FLUSH, 0, 32'h0, 0));
  endtask

  task automatic test_random_traffic(int items_per_phase);
    for (int i = 0; i < 24; i++) begin
      send_item(make_item(OP_LOAD, $urandom_range(0, 255), $urandom, $urandom_range(1, 32)));
    end
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 79 : 0;
      recv_idle_pct = (phase == 0) ? 79 : (phase == 1) ? 19 : 0;
      for (int i = 0; i < items_per_phase; i++) begin
        send_item(random_item());
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_output_backpressure();
    test_random_traffic(62);
    stop_sending();
    while (expected_bytes.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[prefix_code_bit_packer] OK");
    end else begin
      $display("[prefix_code_bit_packer] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
